// File: hdl/mcal_pkg.sv
// Shared types, constants and the microcode table of the magnetometer calibration datapath.
package mcal_pkg;

  localparam int BAD_SAMPLE_LIMIT = 5;
  localparam int COEF_FRAC_BITS   = 14;

  localparam int RAW_W  = 16;
  localparam int D_W    = RAW_W + 1;
  localparam int COEF_W = 16;
  localparam int OUT_W  = 20;
  localparam int MUL_W  = OUT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 35;
  localparam int CORR_W = ACC_W - COEF_FRAC_BITS;
  localparam int MAP_W  = CORR_W + 2;
  localparam int SQ_W   = 2 * OUT_W;
  localparam int ROOT_W = OUT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int ITER_W = $clog2(ROOT_W);
  localparam int CNT_W  = 3;
  localparam int PC_W   = 5;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int ROW_W  = 3 * COEF_W;

  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;

  localparam logic [ROW_W-1:0] ROW_ONE_RST   = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_TWO_RST   = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_THREE_RST = 48'h4000_0000_0000;
  localparam logic [8:0]       AXIS_MAP_RST  = 9'd209;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_REJECT = 2'd1,
    ST_REINIT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_OFFSET_Z  = 3'd2,
    REG_ROW_ONE   = 3'd3,
    REG_ROW_TWO   = 3'd4,
    REG_ROW_THREE = 3'd5,
    REG_AXIS_MAP  = 3'd6,
    REG_Z_ROT     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } in_pkt_t;

  typedef struct packed {
    status_t                 sample_status;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic [ROOT_W-1:0]       magnitude;
  } out_pkt_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] offset_x;
    logic signed [RAW_W-1:0] offset_y;
    logic signed [RAW_W-1:0] offset_z;
    logic [ROW_W-1:0]        row_one;
    logic [ROW_W-1:0]        row_two;
    logic [ROW_W-1:0]        row_three;
    logic [8:0]              axis_map;
    logic [1:0]              z_rotation;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MAC,
    OP_STORE,
    OP_MAP,
    OP_SQ,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_DONE
  } op_t;

  typedef enum logic {
    JC_NEXT,
    JC_ROOT_LOOP
  } jc_t;

  // One microcode word: datapath operation, operand selects and branch.
  typedef struct packed {
    op_t             op;
    logic [1:0]      row;
    logic [1:0]      col;
    logic            clr;
    jc_t             cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic       clr;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_ROOT  = 5'd17;
  localparam logic [PC_W-1:0] PC_DONE  = 5'd18;

  function automatic ucw_t mk(op_t op, logic [1:0] row, logic [1:0] col, logic clr);
    ucw_t w;
    w.op     = op;
    w.row    = row;
    w.col    = col;
    w.clr    = clr;
    w.cond   = JC_NEXT;
    w.target = PC_START;
    return w;
  endfunction

  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:    w = mk(OP_MAC,   2'd0, 2'd0, 1'b1);
      5'd1:    w = mk(OP_MAC,   2'd0, 2'd1, 1'b0);
      5'd2:    w = mk(OP_MAC,   2'd0, 2'd2, 1'b0);
      5'd3:    w = mk(OP_STORE, 2'd0, 2'd0, 1'b0);
      5'd4:    w = mk(OP_MAC,   2'd1, 2'd0, 1'b1);
      5'd5:    w = mk(OP_MAC,   2'd1, 2'd1, 1'b0);
      5'd6:    w = mk(OP_MAC,   2'd1, 2'd2, 1'b0);
      5'd7:    w = mk(OP_STORE, 2'd1, 2'd0, 1'b0);
      5'd8:    w = mk(OP_MAC,   2'd2, 2'd0, 1'b1);
      5'd9:    w = mk(OP_MAC,   2'd2, 2'd1, 1'b0);
      5'd10:   w = mk(OP_MAC,   2'd2, 2'd2, 1'b0);
      5'd11:   w = mk(OP_STORE, 2'd2, 2'd0, 1'b0);
      5'd12:   w = mk(OP_MAP,   2'd0, 2'd0, 1'b0);
      5'd13:   w = mk(OP_SQ,    2'd0, 2'd0, 1'b1);
      5'd14:   w = mk(OP_SQ,    2'd0, 2'd1, 1'b0);
      5'd15:   w = mk(OP_SQ,    2'd0, 2'd2, 1'b0);
      5'd16:   w = mk(OP_ROOT_INIT, 2'd0, 2'd0, 1'b0);
      5'd17: begin
        w = mk(OP_ROOT_STEP, 2'd0, 2'd0, 1'b0);
        w.cond   = JC_ROOT_LOOP;
        w.target = PC_ROOT;
      end
      5'd18:   w = mk(OP_DONE,  2'd0, 2'd0, 1'b0);
      default: w = mk(OP_DONE,  2'd0, 2'd0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/magnetometer_calibration_datapath.sv
// Top level: configuration registers, microcode sequencer and result register.
//
//  Channel  Handshake                 Payload
//  in_      in_valid / in_ready       in_data  (raw_x, raw_y, raw_z)
//  out_     out_valid / out_ready     out_data (sample_status, out_x/y/z, magnitude)
//  config   psel/penable/pwrite, pready   paddr[5:3] register, pwdata/prdata 64 bits
//
// A good sample runs the 19-step microprogram: nine multiply-accumulates on the
// shared multiplier, three roundings, mapping, three squares, the root setup and
// twenty square root steps. out_valid rises when the final step completes and
// in_ready returns with it. A rejected sample jumps straight to the final step.
// The final step waits while the previous result is still held; in_ready is
// high whenever no sample is in flight. Reset is synchronous and loads the
// identity calibration.
module magnetometer_calibration_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mcal_pkg::in_pkt_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mcal_pkg::out_pkt_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcal_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcal_pkg::DATA_W-1:0]   pwdata,
  output logic [mcal_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  mcal_pkg::cfg_t                  cfg_r;
  logic                            busy_r;
  logic [mcal_pkg::PC_W-1:0]       pc_r, pc_nxt;
  logic [mcal_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  mcal_pkg::status_t               status_r, status_nxt;
  logic                            out_valid_r;
  mcal_pkg::out_pkt_t              out_data_r;

  mcal_pkg::ucw_t                  ucw;
  mcal_pkg::ctl_t                  ctl;
  mcal_pkg::reg_idx_t              reg_idx;
  logic                            cfg_wr;
  logic                            accept;
  logic                            bad;
  logic                            done_go;
  logic [mcal_pkg::CNT_W-1:0]      cnt_inc;
  logic                            root_last;
  logic signed [mcal_pkg::OUT_W-1:0] t_x, t_y, t_z;
  logic [mcal_pkg::ROOT_W-1:0]     root;

  assign pready   = 1'b1;
  assign reg_idx  = mcal_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign ucw      = mcal_pkg::ucode(pc_r);

  always_comb begin
    case (reg_idx)
      mcal_pkg::REG_OFFSET_X:  prdata = {48'd0, cfg_r.offset_x};
      mcal_pkg::REG_OFFSET_Y:  prdata = {48'd0, cfg_r.offset_y};
      mcal_pkg::REG_OFFSET_Z:  prdata = {48'd0, cfg_r.offset_z};
      mcal_pkg::REG_ROW_ONE:   prdata = {16'd0, cfg_r.row_one};
      mcal_pkg::REG_ROW_TWO:   prdata = {16'd0, cfg_r.row_two};
      mcal_pkg::REG_ROW_THREE: prdata = {16'd0, cfg_r.row_three};
      mcal_pkg::REG_AXIS_MAP:  prdata = {55'd0, cfg_r.axis_map};
      mcal_pkg::REG_Z_ROT:     prdata = {62'd0, cfg_r.z_rotation};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x   <= '0;
      cfg_r.offset_y   <= '0;
      cfg_r.offset_z   <= '0;
      cfg_r.row_one    <= mcal_pkg::ROW_ONE_RST;
      cfg_r.row_two    <= mcal_pkg::ROW_TWO_RST;
      cfg_r.row_three  <= mcal_pkg::ROW_THREE_RST;
      cfg_r.axis_map   <= mcal_pkg::AXIS_MAP_RST;
      cfg_r.z_rotation <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mcal_pkg::REG_OFFSET_X:  cfg_r.offset_x   <= pwdata[15:0];
        mcal_pkg::REG_OFFSET_Y:  cfg_r.offset_y   <= pwdata[15:0];
        mcal_pkg::REG_OFFSET_Z:  cfg_r.offset_z   <= pwdata[15:0];
        mcal_pkg::REG_ROW_ONE:   cfg_r.row_one    <= pwdata[47:0];
        mcal_pkg::REG_ROW_TWO:   cfg_r.row_two    <= pwdata[47:0];
        mcal_pkg::REG_ROW_THREE: cfg_r.row_three  <= pwdata[47:0];
        mcal_pkg::REG_AXIS_MAP:  cfg_r.axis_map   <= pwdata[8:0];
        mcal_pkg::REG_Z_ROT:     cfg_r.z_rotation <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bad = (in_data.raw_x == '0 && in_data.raw_y == '0 && in_data.raw_z == '0) ||
          in_data.raw_x == mcal_pkg::RAW_MAX || in_data.raw_y == mcal_pkg::RAW_MAX ||
          in_data.raw_z == mcal_pkg::RAW_MAX ||
          in_data.raw_x == mcal_pkg::RAW_MIN || in_data.raw_y == mcal_pkg::RAW_MIN ||
          in_data.raw_z == mcal_pkg::RAW_MIN;
    cnt_inc    = cnt_r + 1'b1;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    if (accept) begin
      if (!bad) begin
        cnt_nxt    = '0;
        status_nxt = mcal_pkg::ST_VALID;
      end else if (cnt_inc >= mcal_pkg::CNT_W'(mcal_pkg::BAD_SAMPLE_LIMIT)) begin
        cnt_nxt    = '0;
        status_nxt = mcal_pkg::ST_REINIT;
      end else begin
        cnt_nxt    = cnt_inc;
        status_nxt = mcal_pkg::ST_REJECT;
      end
    end

    done_go = busy_r && ucw.op == mcal_pkg::OP_DONE && (!out_valid_r || out_ready);

    pc_nxt = pc_r;
    if (accept) begin
      pc_nxt = bad ? mcal_pkg::PC_DONE : mcal_pkg::PC_START;
    end else if (busy_r && ucw.op != mcal_pkg::OP_DONE) begin
      if (ucw.cond == mcal_pkg::JC_ROOT_LOOP && !root_last) begin
        pc_nxt = ucw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end

    ctl.load = accept;
    ctl.op   = busy_r ? ucw.op : mcal_pkg::OP_NOP;
    ctl.row  = ucw.row;
    ctl.col  = ucw.col;
    ctl.clr  = ucw.clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= mcal_pkg::PC_START;
      cnt_r       <= '0;
      status_r    <= mcal_pkg::ST_VALID;
      out_valid_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done_go) begin
        busy_r <= 1'b0;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Rejected samples report zeros in every numeric field.
  always_ff @(posedge clk) begin
    if (done_go) begin
      out_data_r.sample_status <= status_r;
      if (status_r == mcal_pkg::ST_VALID) begin
        out_data_r.out_x     <= t_x;
        out_data_r.out_y     <= t_y;
        out_data_r.out_z     <= t_z;
        out_data_r.magnitude <= root;
      end else begin
        out_data_r.out_x     <= '0;
        out_data_r.out_y     <= '0;
        out_data_r.out_z     <= '0;
        out_data_r.magnitude <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mcal_dp u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .raw       (in_data),
    .root_last (root_last),
    .t_x       (t_x),
    .t_y       (t_y),
    .t_z       (t_z),
    .root      (root)
  );

endmodule

// File: hdl/mcal_dp.sv
// Arithmetic datapath: shared multiplier, accumulators, axis mapping and square root.
module mcal_dp (
  input  logic                          clk,
  input  mcal_pkg::ctl_t                ctl,
  input  mcal_pkg::cfg_t                cfg,
  input  mcal_pkg::in_pkt_t             raw,
  output logic                          root_last,
  output logic signed [mcal_pkg::OUT_W-1:0] t_x,
  output logic signed [mcal_pkg::OUT_W-1:0] t_y,
  output logic signed [mcal_pkg::OUT_W-1:0] t_z,
  output logic [mcal_pkg::ROOT_W-1:0]   root
);

  localparam logic [mcal_pkg::ACC_W-1:0] RND_HALF =
    mcal_pkg::ACC_W'(1) << (mcal_pkg::COEF_FRAC_BITS - 1);

  logic signed [mcal_pkg::D_W-1:0]    d_r   [3];
  logic signed [mcal_pkg::CORR_W-1:0] c_r   [3];
  logic signed [mcal_pkg::OUT_W-1:0]  t_r   [3];
  logic signed [mcal_pkg::ACC_W-1:0]  acc_r;
  logic [mcal_pkg::SQ_W-1:0]          sq_r;
  logic [mcal_pkg::SQ_W-1:0]          n_r;
  logic [mcal_pkg::REM_W-1:0]         rem_r;
  logic [mcal_pkg::ROOT_W-1:0]        root_r;
  logic [mcal_pkg::ITER_W-1:0]        iter_r;

  logic [mcal_pkg::ROW_W-1:0]          row_sel;
  logic signed [mcal_pkg::COEF_W-1:0]  coef;
  logic signed [mcal_pkg::D_W-1:0]     d_sel;
  logic signed [mcal_pkg::OUT_W-1:0]   t_sel;
  logic signed [mcal_pkg::MUL_W-1:0]   mul_a;
  logic signed [mcal_pkg::MUL_W-1:0]   mul_b;
  logic signed [mcal_pkg::PROD_W-1:0]  prod;
  logic signed [mcal_pkg::ACC_W-1:0]   acc_nxt;
  logic signed [mcal_pkg::ACC_W-1:0]   rnd;
  logic signed [mcal_pkg::CORR_W-1:0]  corr;
  logic [mcal_pkg::SQ_W-1:0]           sq_nxt;
  logic signed [mcal_pkg::MAP_W-1:0]   mx, my, mz, tx, ty;
  logic [mcal_pkg::REM_W-1:0]          rem_sh;
  logic [mcal_pkg::REM_W-1:0]          trial;
  logic                                ge;

  function automatic logic signed [mcal_pkg::MAP_W-1:0] pick(
    logic [2:0] code,
    logic signed [mcal_pkg::CORR_W-1:0] cx,
    logic signed [mcal_pkg::CORR_W-1:0] cy,
    logic signed [mcal_pkg::CORR_W-1:0] cz
  );
    logic signed [mcal_pkg::MAP_W-1:0] v;
    case (code)
      3'b001, 3'b111: v = mcal_pkg::MAP_W'(cx);
      3'b010, 3'b110: v = mcal_pkg::MAP_W'(cy);
      3'b011, 3'b101: v = mcal_pkg::MAP_W'(cz);
      default:        v = '0;
    endcase
    return code[2] ? -v : v;
  endfunction

  function automatic logic signed [mcal_pkg::OUT_W-1:0] sat(
    logic signed [mcal_pkg::MAP_W-1:0] v
  );
    logic [mcal_pkg::MAP_W-mcal_pkg::OUT_W:0] upper;
    logic signed [mcal_pkg::OUT_W-1:0]        r;
    upper = v[mcal_pkg::MAP_W-1:mcal_pkg::OUT_W-1];
    if (upper == '0 || upper == '1) begin
      r = v[mcal_pkg::OUT_W-1:0];
    end else if (v[mcal_pkg::MAP_W-1]) begin
      r = {1'b1, {(mcal_pkg::OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(mcal_pkg::OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    case (ctl.row)
      2'd0:    row_sel = cfg.row_one;
      2'd1:    row_sel = cfg.row_two;
      default: row_sel = cfg.row_three;
    endcase
    case (ctl.col)
      2'd0: begin
        coef  = row_sel[15:0];
        d_sel = d_r[0];
        t_sel = t_r[0];
      end
      2'd1: begin
        coef  = row_sel[31:16];
        d_sel = d_r[1];
        t_sel = t_r[1];
      end
      default: begin
        coef  = row_sel[47:32];
        d_sel = d_r[2];
        t_sel = t_r[2];
      end
    endcase

    if (ctl.op == mcal_pkg::OP_SQ) begin
      mul_a = t_sel;
      mul_b = t_sel;
    end else begin
      mul_a = mcal_pkg::MUL_W'(coef);
      mul_b = mcal_pkg::MUL_W'(d_sel);
    end
    prod    = mul_a * mul_b;
    acc_nxt = (ctl.clr ? '0 : acc_r) + mcal_pkg::ACC_W'(prod);
    sq_nxt  = (ctl.clr ? '0 : sq_r) + $unsigned(prod);

    // Round half up, then drop the fraction bits.
    rnd  = acc_r + $signed(RND_HALF);
    corr = rnd[mcal_pkg::ACC_W-1:mcal_pkg::COEF_FRAC_BITS];

    mx = pick(cfg.axis_map[2:0], c_r[0], c_r[1], c_r[2]);
    my = pick(cfg.axis_map[5:3], c_r[0], c_r[1], c_r[2]);
    mz = pick(cfg.axis_map[8:6], c_r[0], c_r[1], c_r[2]);
    case (cfg.z_rotation)
      2'd1: begin
        tx = my;
        ty = -mx;
      end
      2'd2: begin
        tx = -mx;
        ty = -my;
      end
      2'd3: begin
        tx = -my;
        ty = mx;
      end
      default: begin
        tx = mx;
        ty = my;
      end
    endcase

    // Restoring square root, one result bit per step.
    rem_sh = {rem_r[mcal_pkg::REM_W-3:0], n_r[mcal_pkg::SQ_W-1:mcal_pkg::SQ_W-2]};
    trial  = {root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_r[0] <= mcal_pkg::D_W'(raw.raw_x) - mcal_pkg::D_W'(cfg.offset_x);
      d_r[1] <= mcal_pkg::D_W'(raw.raw_y) - mcal_pkg::D_W'(cfg.offset_y);
      d_r[2] <= mcal_pkg::D_W'(raw.raw_z) - mcal_pkg::D_W'(cfg.offset_z);
    end
    case (ctl.op)
      mcal_pkg::OP_MAC: acc_r <= acc_nxt;
      mcal_pkg::OP_STORE: begin
        case (ctl.row)
          2'd0:    c_r[0] <= corr;
          2'd1:    c_r[1] <= corr;
          default: c_r[2] <= corr;
        endcase
      end
      mcal_pkg::OP_MAP: begin
        t_r[0] <= sat(tx);
        t_r[1] <= sat(ty);
        t_r[2] <= sat(mz);
      end
      mcal_pkg::OP_SQ: sq_r <= sq_nxt;
      mcal_pkg::OP_ROOT_INIT: begin
        n_r    <= sq_r;
        rem_r  <= '0;
        root_r <= '0;
        iter_r <= '0;
      end
      mcal_pkg::OP_ROOT_STEP: begin
        n_r    <= {n_r[mcal_pkg::SQ_W-3:0], 2'b00};
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[mcal_pkg::ROOT_W-2:0], ge};
        iter_r <= iter_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign root_last = (iter_r == mcal_pkg::ITER_W'(mcal_pkg::ROOT_W - 1));
  assign t_x  = t_r[0];
  assign t_y  = t_r[1];
  assign t_z  = t_r[2];
  assign root = root_r;

endmodule

// File: hdl/mcal_chk.sv
// Port-level checker for the magnetometer calibration datapath, with its bind.
module mcal_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mcal_pkg::out_pkt_t out_data
);

  logic [mcal_pkg::OUT_W-1:0] abs_x, abs_y, abs_z;
  logic                       good_out;

  always_comb begin
    abs_x    = out_data.out_x[mcal_pkg::OUT_W-1] ? -out_data.out_x : out_data.out_x;
    abs_y    = out_data.out_y[mcal_pkg::OUT_W-1] ? -out_data.out_y : out_data.out_y;
    abs_z    = out_data.out_z[mcal_pkg::OUT_W-1] ? -out_data.out_z : out_data.out_z;
    good_out = out_valid && out_data.sample_status == mcal_pkg::ST_VALID;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new sample taken while one is in flight");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sample_status != mcal_pkg::ST_VALID |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0 &&
      out_data.magnitude == '0)
    else $error("rejected sample carries nonzero data");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    good_out |-> out_data.magnitude >= abs_x && out_data.magnitude >= abs_y &&
      out_data.magnitude >= abs_z)
    else $error("magnitude smaller than an axis");

endmodule

bind magnetometer_calibration_datapath mcal_chk u_mcal_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
